// File: sv/intruder_alarm_controller_assert.svh
`ifndef INTRUDER_ALARM_CONTROLLER_ASSERT_SVH
`define INTRUDER_ALARM_CONTROLLER_ASSERT_SVH

// Checks a condition that must hold in the same cycle as its trigger.
`define IAC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a condition that must hold in the cycle after its trigger.
`define IAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/iac_pkg.sv
package iac_pkg;

  localparam int MODE_W     = 3;
  localparam int HITS_W     = 4;
  localparam int STATE_W    = 3;
  localparam int SECS_W     = 8;
  localparam int EVENT_W    = 3;
  localparam int TRIG_W     = 2;
  localparam int DELAY_W    = 16;
  localparam int NUM_SENSORS = 4;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [DELAY_W-1:0] EXIT_DELAY_RESET  = 16'd30000;
  localparam logic [DELAY_W-1:0] ENTRY_DELAY_RESET = 16'd15000;

  // Register byte addresses on the configuration port.
  localparam logic [PADDR_W-1:0] ADDR_EXIT_DELAY  = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_ENTRY_DELAY = 3'd4;

  typedef enum logic [STATE_W-1:0] {
    ST_OFF    = 3'd0,
    ST_ARMING = 3'd1,
    ST_ARMED  = 3'd2,
    ST_MOTION = 3'd3,
    ST_ALARM  = 3'd4
  } alarm_state_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE     = 3'd0,
    EV_DISARMED = 3'd1,
    EV_ARMING   = 3'd2,
    EV_ARMED    = 3'd3,
    EV_MOTION   = 3'd4,
    EV_ALARM    = 3'd5
  } event_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK        = 3'd0,
    MODE_ARM_DELAYED = 3'd1,
    MODE_ARM_NOW     = 3'd2,
    MODE_DISARM      = 3'd3,
    MODE_STATUS      = 3'd4,
    MODE_SENSORS     = 3'd5
  } mode_t;

endpackage

// File: sv/iac_in_if.sv
interface iac_in_if;
  logic                        valid;
  logic                        ready;
  logic [iac_pkg::MODE_W-1:0]  mode;
  logic [iac_pkg::HITS_W-1:0]  sensor_hits;

  modport source (output valid, output mode, output sensor_hits, input ready);
  modport sink   (input valid, input mode, input sensor_hits, output ready);
endinterface

// File: sv/iac_out_if.sv
interface iac_out_if;
  logic                               valid;
  logic                               ready;
  logic [iac_pkg::STATE_W-1:0]        alarm_state;
  logic                               accepted;
  logic signed [iac_pkg::SECS_W-1:0]  seconds_left;
  logic                               siren_on;
  logic [iac_pkg::EVENT_W-1:0]        event_res;
  logic [iac_pkg::TRIG_W-1:0]         trigger_sensor;

  modport source (output valid, output alarm_state, output accepted, output seconds_left,
                  output siren_on, output event_res, output trigger_sensor, input ready);
  modport sink   (input valid, input alarm_state, input accepted, input seconds_left,
                  input siren_on, input event_res, input trigger_sensor, output ready);
endinterface

// File: sv/intruder_alarm_controller.sv
// Intruder alarm controller with exit and entry delays. Each input beat (a
// millisecond tick, a command, a status query or a sensor hit vector) yields
// exactly one result beat that reports the state after the item. The block
// takes one beat per clock cycle unless the output stalls: the whole update is
// a single combinational pass from the accepted beat into the state registers
// and the output register, so a result is ready in the cycle after its beat is
// taken, and in_if.ready stays high while the output register is empty or
// being read. The exit and entry delays sit at byte addresses 0x0 and 0x4 of
// the APB port and should only be changed while no result is outstanding.
module intruder_alarm_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  iac_in_if.sink                           in_if,
  iac_out_if.source                        out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [iac_pkg::PADDR_W-1:0]      paddr,
  input  logic [iac_pkg::PDATA_W-1:0]      pwdata,
  output logic [iac_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int DW = iac_pkg::DELAY_W;
  localparam logic [iac_pkg::HITS_W-1:0] HIT_MASK =
    iac_pkg::HITS_W'((1 << iac_pkg::NUM_SENSORS) - 1);
  // ceil(2^26 / 1000); exact for every 16-bit dividend.
  localparam logic [16:0] RECIP_1000 = 17'd67109;
  localparam int RECIP_SHIFT = 26;

  iac_pkg::alarm_state_t state_r, state_nxt;
  logic [DW-1:0]         elapsed_r, elapsed_nxt;
  logic [DW-1:0]         exit_delay_r, entry_delay_r;

  logic                          accepted_nxt;
  iac_pkg::event_t               event_nxt;
  logic [iac_pkg::TRIG_W-1:0]    trig_nxt;
  logic [iac_pkg::HITS_W-1:0]    hits;
  logic [DW-1:0]                 elapsed_inc;
  logic                          in_fire;

  logic                          out_valid_r;
  iac_pkg::alarm_state_t         out_state_r;
  logic                          out_accepted_r;
  logic signed [iac_pkg::SECS_W-1:0] out_secs_r, secs_nxt;
  iac_pkg::event_t               out_event_r;
  logic [iac_pkg::TRIG_W-1:0]    out_trig_r;

  logic [DW-1:0]                 delay_sel;
  logic signed [DW:0]            remain;
  logic [DW+16:0]                quot_prod;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exit_delay_r  <= iac_pkg::EXIT_DELAY_RESET;
      entry_delay_r <= iac_pkg::ENTRY_DELAY_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == iac_pkg::ADDR_ENTRY_DELAY[2]) begin
        entry_delay_r <= pwdata[DW-1:0];
      end else begin
        exit_delay_r <= pwdata[DW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == iac_pkg::ADDR_ENTRY_DELAY[2]) begin
      prdata = {{(iac_pkg::PDATA_W-DW){1'b0}}, entry_delay_r};
    end else begin
      prdata = {{(iac_pkg::PDATA_W-DW){1'b0}}, exit_delay_r};
    end
  end

  // ---------------- state machine ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= iac_pkg::ST_OFF;
      elapsed_r <= '0;
    end else if (in_fire) begin
      state_r   <= state_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  assign hits        = in_if.sensor_hits & HIT_MASK;
  assign elapsed_inc = (elapsed_r == {DW{1'b1}}) ? elapsed_r : elapsed_r + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    elapsed_nxt  = elapsed_r;
    accepted_nxt = 1'b0;
    event_nxt    = iac_pkg::EV_NONE;
    trig_nxt     = '0;
    case (in_if.mode)
      iac_pkg::MODE_TICK: begin
        if (state_r == iac_pkg::ST_ARMING) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= exit_delay_r) begin
            state_nxt = iac_pkg::ST_ARMED;
            event_nxt = iac_pkg::EV_ARMED;
          end
        end else if (state_r == iac_pkg::ST_MOTION) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= entry_delay_r) begin
            state_nxt = iac_pkg::ST_ALARM;
            event_nxt = iac_pkg::EV_ALARM;
          end
        end
      end
      iac_pkg::MODE_ARM_DELAYED: begin
        if (state_r == iac_pkg::ST_OFF) begin
          state_nxt    = iac_pkg::ST_ARMING;
          elapsed_nxt  = '0;
          accepted_nxt = 1'b1;
          event_nxt    = iac_pkg::EV_ARMING;
        end
      end
      iac_pkg::MODE_ARM_NOW: begin
        if (state_r == iac_pkg::ST_OFF || state_r == iac_pkg::ST_ARMING) begin
          state_nxt    = iac_pkg::ST_ARMED;
          accepted_nxt = 1'b1;
          event_nxt    = iac_pkg::EV_ARMED;
        end
      end
      iac_pkg::MODE_DISARM: begin
        if (state_r != iac_pkg::ST_OFF) begin
          state_nxt    = iac_pkg::ST_OFF;
          accepted_nxt = 1'b1;
          event_nxt    = iac_pkg::EV_DISARMED;
        end
      end
      iac_pkg::MODE_SENSORS: begin
        if (state_r == iac_pkg::ST_ARMED && hits != '0) begin
          state_nxt   = iac_pkg::ST_MOTION;
          elapsed_nxt = '0;
          event_nxt   = iac_pkg::EV_MOTION;
          // Lowest set bit wins, so scan from the top down.
          for (int i = iac_pkg::HITS_W - 1; i >= 0; i--) begin
            if (hits[i]) begin
              trig_nxt = iac_pkg::TRIG_W'(i);
            end
          end
        end
      end
      default: begin
        // Status query and the unused modes leave everything as it is.
      end
    endcase
  end

  // ---------------- seconds remaining ----------------
  assign delay_sel = (state_nxt == iac_pkg::ST_ARMING) ? exit_delay_r : entry_delay_r;
  assign remain    = $signed({1'b0, delay_sel}) - $signed({1'b0, elapsed_nxt});
  assign quot_prod = remain[DW-1:0] * RECIP_1000;

  always_comb begin
    if (state_nxt != iac_pkg::ST_ARMING && state_nxt != iac_pkg::ST_MOTION) begin
      secs_nxt = -8'sd1;
    end else if (!remain[DW]) begin
      secs_nxt = $signed(iac_pkg::SECS_W'(quot_prod >> RECIP_SHIFT));
    end else if (remain > -17'sd1000) begin
      secs_nxt = 8'sd0;
    end else begin
      secs_nxt = -8'sd1;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_state_r    <= state_nxt;
      out_accepted_r <= accepted_nxt;
      out_secs_r     <= secs_nxt;
      out_event_r    <= event_nxt;
      out_trig_r     <= trig_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.alarm_state    = out_state_r;
  assign out_if.accepted       = out_accepted_r;
  assign out_if.seconds_left   = out_secs_r;
  assign out_if.siren_on       = (out_state_r == iac_pkg::ST_ALARM);
  assign out_if.event_res      = out_event_r;
  assign out_if.trigger_sensor = out_trig_r;

  // ---------------- assertions ----------------
`include "intruder_alarm_controller_assert.svh"

  // A pending result always reports the state the controller is in.
  `IAC_ASSERT_SAME(a_out_matches_state, out_valid_r, out_state_r == state_r, "result state differs from controller state")

  `IAC_ASSERT_NEXT(a_arm_delayed_starts, in_fire && in_if.mode == iac_pkg::MODE_ARM_DELAYED && state_r == iac_pkg::ST_OFF, state_r == iac_pkg::ST_ARMING && elapsed_r == '0, "arm with delay did not start a fresh countdown")

  `IAC_ASSERT_NEXT(a_alarm_holds_on_tick, in_fire && in_if.mode == iac_pkg::MODE_TICK && state_r == iac_pkg::ST_ALARM, state_r == iac_pkg::ST_ALARM && out_event_r == iac_pkg::EV_NONE, "tick changed the alarm state")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int MS_PER_S       = 1000;
  localparam int MAX_GAP        = 14;
  localparam int LIMIT_CYCLES   = 400000;
  localparam int IDLE_CYCLES    = 4;
  localparam int HOLD_AT_BEAT   = 500;
  localparam int HOLD_CYCLES    = 300;
  localparam int LONG_TICKS     = 1000;
  localparam int RAND_PHASES    = 14;
  localparam int PHASE_ITEMS    = 60;
  localparam int DIR_ROWS       = 26;

  localparam logic [iac_pkg::MODE_W-1:0]        MODE_SPARE6 = 3'd6;
  localparam logic signed [iac_pkg::SECS_W-1:0] NO_SECS     = -8'sd1;
  localparam logic [iac_pkg::DELAY_W-1:0]       DELAY_MAX   = 16'hFFFF;

  typedef struct packed {
    iac_pkg::alarm_state_t             st;
    logic                              acc;
    logic signed [iac_pkg::SECS_W-1:0] secs;
    logic                              siren;
    iac_pkg::event_t                   ev;
    logic [iac_pkg::TRIG_W-1:0]        trig;
  } alarm_result_t;

  typedef struct packed {
    logic [iac_pkg::MODE_W-1:0] mode;
    logic [iac_pkg::HITS_W-1:0] hits;
  } alarm_cmd_t;

  typedef struct packed {
    logic                        wr;
    logic [iac_pkg::DELAY_W-1:0] exit_ms;
    logic [iac_pkg::DELAY_W-1:0] entry_ms;
    alarm_cmd_t                  cmd;
    alarm_result_t               res;
  } alarm_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [iac_pkg::PADDR_W-1:0] paddr;
  logic [iac_pkg::PDATA_W-1:0] pwdata;
  logic [iac_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  iac_in_if  in_ch();
  iac_out_if out_ch();

  intruder_alarm_controller dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Mirror of the controller state and its two delay registers.
  iac_pkg::alarm_state_t       pred_state;
  logic [iac_pkg::DELAY_W-1:0] pred_elapsed;
  logic [iac_pkg::DELAY_W-1:0] pred_exit_ms;
  logic [iac_pkg::DELAY_W-1:0] pred_entry_ms;

  alarm_result_t due_results[$];
  alarm_cmd_t    cmd_backlog[$];
  int            n_errors = 0;
  int            cycles = 0;
  int            rx_beats = 0;
  bit            tx_quiet = 1'b0;
  bit            rx_quiet = 1'b0;

  // Directed rows; rows with wr set reprogram both delays before the beat.
  alarm_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_STATUS, 4'h0},
      '{iac_pkg::ST_OFF, 1'b0, NO_SECS, 1'b0, iac_pkg::EV_NONE, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_SENSORS, 4'hF},
      '{iac_pkg::ST_OFF, 1'b0, NO_SECS, 1'b0, iac_pkg::EV_NONE, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_ARM_DELAYED, 4'h0},
      '{iac_pkg::ST_ARMING, 1'b1, 8'sd30, 1'b0, iac_pkg::EV_ARMING, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_TICK, 4'h0},
      '{iac_pkg::ST_ARMING, 1'b0, 8'sd29, 1'b0, iac_pkg::EV_NONE, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_SENSORS, 4'hF},
      '{iac_pkg::ST_ARMING, 1'b0, 8'sd29, 1'b0, iac_pkg::EV_NONE, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_ARM_NOW, 4'h0},
      '{iac_pkg::ST_ARMED, 1'b1, NO_SECS, 1'b0, iac_pkg::EV_ARMED, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_ARM_DELAYED, 4'h0},
      '{iac_pkg::ST_ARMED, 1'b0, NO_SECS, 1'b0, iac_pkg::EV_NONE, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_SENSORS, 4'h0},
      '{iac_pkg::ST_ARMED, 1'b0, NO_SECS, 1'b0, iac_pkg::EV_NONE, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_SENSORS, 4'h8},
      '{iac_pkg::ST_MOTION, 1'b0, 8'sd15, 1'b0, iac_pkg::EV_MOTION, 2'd3}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_TICK, 4'h0},
      '{iac_pkg::ST_MOTION, 1'b0, 8'sd14, 1'b0, iac_pkg::EV_NONE, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_SENSORS, 4'h1},
      '{iac_pkg::ST_MOTION, 1'b0, 8'sd14, 1'b0, iac_pkg::EV_NONE, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{MODE_SPARE6, 4'h0},
      '{iac_pkg::ST_MOTION, 1'b0, 8'sd14, 1'b0, iac_pkg::EV_NONE, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_DISARM, 4'h0},
      '{iac_pkg::ST_OFF, 1'b1, NO_SECS, 1'b0, iac_pkg::EV_DISARMED, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_DISARM, 4'h0},
      '{iac_pkg::ST_OFF, 1'b0, NO_SECS, 1'b0, iac_pkg::EV_NONE, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_ARM_NOW, 4'h0},
      '{iac_pkg::ST_ARMED, 1'b1, NO_SECS, 1'b0, iac_pkg::EV_ARMED, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_SENSORS, 4'h6},
      '{iac_pkg::ST_MOTION, 1'b0, 8'sd15, 1'b0, iac_pkg::EV_MOTION, 2'd1}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_DISARM, 4'h0},
      '{iac_pkg::ST_OFF, 1'b1, NO_SECS, 1'b0, iac_pkg::EV_DISARMED, 2'd0}},
    '{1'b1, 16'd0, 16'd0, '{iac_pkg::MODE_ARM_DELAYED, 4'h0},
      '{iac_pkg::ST_ARMING, 1'b1, 8'sd0, 1'b0, iac_pkg::EV_ARMING, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_TICK, 4'h0},
      '{iac_pkg::ST_ARMED, 1'b0, NO_SECS, 1'b0, iac_pkg::EV_ARMED, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_SENSORS, 4'h4},
      '{iac_pkg::ST_MOTION, 1'b0, 8'sd0, 1'b0, iac_pkg::EV_MOTION, 2'd2}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_TICK, 4'h0},
      '{iac_pkg::ST_ALARM, 1'b0, NO_SECS, 1'b1, iac_pkg::EV_ALARM, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_ARM_NOW, 4'h0},
      '{iac_pkg::ST_ALARM, 1'b0, NO_SECS, 1'b1, iac_pkg::EV_NONE, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_DISARM, 4'h0},
      '{iac_pkg::ST_OFF, 1'b1, NO_SECS, 1'b0, iac_pkg::EV_DISARMED, 2'd0}},
    '{1'b1, 16'hFFFF, 16'hFFFF, '{iac_pkg::MODE_ARM_DELAYED, 4'h0},
      '{iac_pkg::ST_ARMING, 1'b1, 8'sd65, 1'b0, iac_pkg::EV_ARMING, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_ARM_NOW, 4'h0},
      '{iac_pkg::ST_ARMED, 1'b1, NO_SECS, 1'b0, iac_pkg::EV_ARMED, 2'd0}},
    '{1'b0, 16'd0, 16'd0, '{iac_pkg::MODE_SENSORS, 4'h2},
      '{iac_pkg::ST_MOTION, 1'b0, 8'sd65, 1'b0, iac_pkg::EV_MOTION, 2'd1}}
  };

  // Whole seconds left; a small overrun still reads as zero.
  function automatic logic signed [iac_pkg::SECS_W-1:0] secs_remaining(
      logic [iac_pkg::DELAY_W-1:0] dly);
    int r;
    r = int'(dly) - int'(pred_elapsed);
    if (r >= 0) return iac_pkg::SECS_W'(r / MS_PER_S);
    if (r > -MS_PER_S) return '0;
    return NO_SECS;
  endfunction

  function automatic alarm_result_t alarm_step(alarm_cmd_t c);
    alarm_result_t              r;
    logic [iac_pkg::HITS_W-1:0] live;
    r = '{st: iac_pkg::ST_OFF, acc: 1'b0, secs: NO_SECS, siren: 1'b0,
          ev: iac_pkg::EV_NONE, trig: '0};
    case (c.mode)
      iac_pkg::MODE_TICK: begin
        if (pred_state == iac_pkg::ST_ARMING || pred_state == iac_pkg::ST_MOTION) begin
          if (pred_elapsed != DELAY_MAX) pred_elapsed = pred_elapsed + 1'b1;
          if (pred_state == iac_pkg::ST_ARMING && pred_elapsed >= pred_exit_ms) begin
            pred_state = iac_pkg::ST_ARMED;
            r.ev = iac_pkg::EV_ARMED;
          end else if (pred_state == iac_pkg::ST_MOTION && pred_elapsed >= pred_entry_ms) begin
            pred_state = iac_pkg::ST_ALARM;
            r.ev = iac_pkg::EV_ALARM;
          end
        end
      end
      iac_pkg::MODE_ARM_DELAYED: begin
        if (pred_state == iac_pkg::ST_OFF) begin
          pred_state = iac_pkg::ST_ARMING;
          pred_elapsed = '0;
          r.acc = 1'b1;
          r.ev = iac_pkg::EV_ARMING;
        end
      end
      iac_pkg::MODE_ARM_NOW: begin
        if (pred_state == iac_pkg::ST_OFF || pred_state == iac_pkg::ST_ARMING) begin
          pred_state = iac_pkg::ST_ARMED;
          r.acc = 1'b1;
          r.ev = iac_pkg::EV_ARMED;
        end
      end
      iac_pkg::MODE_DISARM: begin
        if (pred_state != iac_pkg::ST_OFF) begin
          pred_state = iac_pkg::ST_OFF;
          r.acc = 1'b1;
          r.ev = iac_pkg::EV_DISARMED;
        end
      end
      iac_pkg::MODE_SENSORS: begin
        live = c.hits & iac_pkg::HITS_W'((1 << iac_pkg::NUM_SENSORS) - 1);
        if (pred_state == iac_pkg::ST_ARMED && live != '0) begin
          pred_state = iac_pkg::ST_MOTION;
          pred_elapsed = '0;
          r.ev = iac_pkg::EV_MOTION;
          for (int i = iac_pkg::HITS_W - 1; i >= 0; i--)
            if (live[i]) r.trig = iac_pkg::TRIG_W'(i);
        end
      end
      default: ;
    endcase
    r.st = pred_state;
    if (pred_state == iac_pkg::ST_ARMING) r.secs = secs_remaining(pred_exit_ms);
    else if (pred_state == iac_pkg::ST_MOTION) r.secs = secs_remaining(pred_entry_ms);
    r.siren = (pred_state == iac_pkg::ST_ALARM);
    return r;
  endfunction

  task automatic check_field(string name, logic signed [31:0] exp_v,
                             logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  task automatic send_cmd(alarm_cmd_t c, bit typed, alarm_result_t res);
    int            gap;
    alarm_result_t pred;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= c.mode;
    in_ch.sensor_hits <= c.hits;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    pred = alarm_step(c);
    due_results.insert(due_results.size(), typed ? res : pred);
  endtask

  // Drops valid and lets the block drain before anything is reprogrammed.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_delay(logic [iac_pkg::PADDR_W-1:0] addr,
                             logic [iac_pkg::DELAY_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= iac_pkg::PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == iac_pkg::ADDR_EXIT_DELAY) pred_exit_ms = val;
    else pred_entry_ms = val;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("readback", iac_pkg::PDATA_W'(val), prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_delays(logic [iac_pkg::DELAY_W-1:0] exit_ms,
                            logic [iac_pkg::DELAY_W-1:0] entry_ms);
    settle();
    write_delay(iac_pkg::ADDR_EXIT_DELAY, exit_ms);
    write_delay(iac_pkg::ADDR_ENTRY_DELAY, entry_ms);
  endtask

  function automatic void queue_cmd(logic [iac_pkg::MODE_W-1:0] m);
    alarm_cmd_t c;
    c.mode = m;
    c.hits = iac_pkg::HITS_W'($urandom);
    cmd_backlog.insert(cmd_backlog.size(), c);
  endfunction

  function automatic int tick_span(logic [iac_pkg::DELAY_W-1:0] d);
    return (d <= 40) ? int'(d) + 2 : 40;
  endfunction

  function automatic logic [iac_pkg::DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DELAY_MAX;
      2: return iac_pkg::DELAY_W'(1);
      3: return iac_pkg::DELAY_W'($urandom_range(0, 2500));
      default: return iac_pkg::DELAY_W'($urandom_range(0, 20));
    endcase
  endfunction

  // Mostly full arm / count / intrude / count / disarm sequences, some noise.
  function automatic void queue_scenario();
    int n;
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) queue_cmd(iac_pkg::MODE_W'($urandom_range(0, 7)));
    end else begin
      if ($urandom_range(0, 3) == 0) queue_cmd(iac_pkg::MODE_DISARM);
      queue_cmd(($urandom_range(0, 3) == 0) ? iac_pkg::MODE_ARM_NOW
                                             : iac_pkg::MODE_ARM_DELAYED);
      n = $urandom_range(0, tick_span(pred_exit_ms));
      repeat (n) queue_cmd(iac_pkg::MODE_TICK);
      queue_cmd(iac_pkg::MODE_SENSORS);
      n = $urandom_range(0, tick_span(pred_entry_ms));
      repeat (n) queue_cmd(iac_pkg::MODE_TICK);
      if ($urandom_range(0, 1) == 0) queue_cmd(iac_pkg::MODE_STATUS);
      if ($urandom_range(0, 3) != 0) queue_cmd(iac_pkg::MODE_DISARM);
    end
  endfunction

  task automatic run_backlog();
    while (cmd_backlog.size() != 0) send_cmd(cmd_backlog.pop_front(), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    alarm_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        n_errors++;
        $display("%0t: result beat with nothing expected, state %0d event %0d",
                 $time, out_ch.alarm_state, out_ch.event_res);
      end else begin
        e = due_results.pop_front();
        check_field("alarm_state", e.st, out_ch.alarm_state);
        check_field("accepted", e.acc, out_ch.accepted);
        check_field("seconds_left", e.secs, out_ch.seconds_left);
        check_field("siren_on", e.siren, out_ch.siren_on);
        check_field("event_res", e.ev, out_ch.event_res);
        check_field("trigger_sensor", e.trig, out_ch.trigger_sensor);
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_beats % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      // One long hold-off so that the output fills and the input backs up.
      if (rx_beats == HOLD_AT_BEAT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      rx_beats++;
    end
  end

  initial begin : stimulus
    int cuts [3];
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= iac_pkg::MODE_TICK;
    in_ch.sensor_hits <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pred_state = iac_pkg::ST_OFF;
    pred_elapsed = '0;
    pred_exit_ms = iac_pkg::EXIT_DELAY_RESET;
    pred_entry_ms = iac_pkg::ENTRY_DELAY_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) set_delays(dir_rows[i].exit_ms, dir_rows[i].entry_ms);
      send_cmd(dir_rows[i].cmd, 1'b1, dir_rows[i].res);
    end

    // Build up a long arming count, then shrink the exit delay under it:
    // an overrun of exactly one second reads as -1, just under it as 0.
    set_delays(DELAY_MAX, DELAY_MAX);
    queue_cmd(iac_pkg::MODE_ARM_DELAYED);
    repeat (LONG_TICKS) queue_cmd(iac_pkg::MODE_TICK);
    run_backlog();
    cuts = '{0, 1, 2000};
    foreach (cuts[i]) begin
      set_delays(iac_pkg::DELAY_W'(cuts[i]), DELAY_MAX);
      queue_cmd(iac_pkg::MODE_STATUS);
      run_backlog();
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      set_delays(pick_delay(), pick_delay());
      tx_quiet = ($urandom_range(0, 3) == 0);
      while (cmd_backlog.size() < PHASE_ITEMS) queue_scenario();
      run_backlog();
    end

    settle();
    if (n_errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

// File: intruder_alarm_controller.f
+incdir+sv
sv/iac_pkg.sv
sv/iac_in_if.sv
sv/iac_out_if.sv
sv/intruder_alarm_controller.sv
tb/sv/tb.sv
